FILE: rtl/core/d8sd_pkg.sv
// ----------------------------------------------------------------------------
// d8sd_pkg
// shared constants and types of the d8 steepest descent direction block
// ----------------------------------------------------------------------------
package d8sd_pkg;

    localparam int MAX_WIDTH       = 4096;
    localparam int ELEV_BITS       = 32;
    localparam int ELEV_FIELD_BITS = 32;
    localparam int COL_BITS        = $clog2(MAX_WIDTH);
    localparam int ROW_BITS        = 16;
    localparam int WCFG_BITS       = 13;
    localparam int HCFG_BITS       = 16;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int DIR_BITS        = 4;
    localparam int NB_BITS         = 3;
    localparam int NB_COUNT        = 8;
    localparam int WEIGHT_FRAC     = 16;
    localparam int DIAG_WEIGHT     = 46341;
    localparam int SCORE_BITS      = ELEV_BITS + WEIGHT_FRAC;
    localparam int MIN_SIZE        = 5;
    localparam int RESET_SIZE      = 4096;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_WIDTH    = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [DIR_BITS-1:0] NO_FLOW = 4'd8;

    typedef struct packed {
        logic                emit;
        logic                ring;
        logic                last;
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
    } ctl_t;

    typedef struct packed {
        logic [NB_BITS-1:0]    idx;
        logic [SCORE_BITS-1:0] score;
    } cand_t;

endpackage

FILE: rtl/core/d8sd_if.sv
// ----------------------------------------------------------------------------
// d8sd_in_if / d8sd_out_if
// valid/ready channels carrying elevation samples and direction results
// ----------------------------------------------------------------------------
interface d8sd_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [d8sd_pkg::ELEV_FIELD_BITS-1:0] elevation;

    modport source (output valid, output elevation, input ready);
    modport sink (input valid, input elevation, output ready);
endinterface

interface d8sd_out_if;
    logic                          valid;
    logic                          ready;
    logic [d8sd_pkg::DIR_BITS-1:0] direction;
    logic [d8sd_pkg::COL_BITS-1:0] cell_column;
    logic [d8sd_pkg::ROW_BITS-1:0] cell_row;
    logic                          frame_last;

    modport source (output valid, output direction, output cell_column, output cell_row,
                    output frame_last, input ready);
    modport sink (input valid, input direction, input cell_column, input cell_row,
                  input frame_last, output ready);
endinterface

FILE: rtl/core/d8sd_ram.sv
// ----------------------------------------------------------------------------
// d8sd_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module d8sd_ram #(
    parameter int WIDTH     = 64,
    parameter int DEPTH     = 4096,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/d8_steepest_descent_direction_top.sv
// ----------------------------------------------------------------------------
// d8_steepest_descent_direction_top
// d8 receiver of every inner cell of a raster streamed in row order
// ----------------------------------------------------------------------------
// Takes one elevation sample per cycle unless the result side stalls, and
// gives one result for every inner cell once the sample that completes its
// 3x3 window is in: the line store read, then drop, weighting multiply and a
// two stage compare tree, each behind a register. The two previous rows live
// in one ram of MAX_WIDTH words, read and written once per item, so the
// sustained rate is one item per clock whenever the result side is ready. The
// line store needs no clearing after reset; the window registers reset to
// zero. row_width and frame_height are clamped on write to their legal range.
module d8_steepest_descent_direction_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                write_enable,
    input  logic [d8sd_pkg::CFG_INDEX_BITS-1:0] write_index,
    input  logic [d8sd_pkg::CFG_DATA_BITS-1:0]  write_data,
    d8sd_in_if.sink                             samples,
    d8sd_out_if.source                          results
);

    localparam int EB = d8sd_pkg::ELEV_BITS;
    localparam int SB = d8sd_pkg::SCORE_BITS;

    // configuration
    logic [d8sd_pkg::WCFG_BITS-1:0] width_reg;
    logic [d8sd_pkg::HCFG_BITS-1:0] height_reg;
    logic [d8sd_pkg::WCFG_BITS-1:0] width_in;
    logic [d8sd_pkg::HCFG_BITS-1:0] height_in;

    assign width_in  = write_data[d8sd_pkg::WCFG_BITS-1:0];
    assign height_in = write_data[d8sd_pkg::HCFG_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= d8sd_pkg::WCFG_BITS'(d8sd_pkg::RESET_SIZE);
            height_reg <= d8sd_pkg::HCFG_BITS'(d8sd_pkg::RESET_SIZE);
        end
        else if (write_enable)
        begin
            case (write_index)
                d8sd_pkg::REG_ROW_WIDTH:
                begin
                    if (width_in < d8sd_pkg::WCFG_BITS'(d8sd_pkg::MIN_SIZE))
                        width_reg <= d8sd_pkg::WCFG_BITS'(d8sd_pkg::MIN_SIZE);
                    else if (width_in > d8sd_pkg::WCFG_BITS'(d8sd_pkg::MAX_WIDTH))
                        width_reg <= d8sd_pkg::WCFG_BITS'(d8sd_pkg::MAX_WIDTH);
                    else
                        width_reg <= width_in;
                end
                d8sd_pkg::REG_FRAME_HEIGHT:
                begin
                    if (height_in < d8sd_pkg::HCFG_BITS'(d8sd_pkg::MIN_SIZE))
                        height_reg <= d8sd_pkg::HCFG_BITS'(d8sd_pkg::MIN_SIZE);
                    else
                        height_reg <= height_in;
                end
                default:
                begin
                end
            endcase
        end
    end

    // pipeline enable
    logic en;
    logic in_fire;
    logic out_valid_reg;

    assign en            = !out_valid_reg || results.ready;
    assign samples.ready = en;
    assign in_fire       = samples.valid && en;

    // position counters and window classification
    logic [d8sd_pkg::COL_BITS-1:0]  col_reg;
    logic [d8sd_pkg::ROW_BITS-1:0]  row_reg;
    logic [d8sd_pkg::COL_BITS-1:0]  col_next;
    logic [d8sd_pkg::ROW_BITS-1:0]  row_next;
    logic [d8sd_pkg::WCFG_BITS-1:0] col_wide;
    logic [d8sd_pkg::WCFG_BITS-1:0] wlast;
    logic [d8sd_pkg::HCFG_BITS-1:0] hlast;
    d8sd_pkg::ctl_t                 ctl_a;

    always_comb
    begin
        col_wide   = {1'b0, col_reg};
        wlast      = width_reg - 1'b1;
        hlast      = height_reg - 1'b1;
        ctl_a.emit = row_reg >= 16'd2 && row_reg <= hlast &&
                     col_reg >= d8sd_pkg::COL_BITS'(2) && col_wide <= wlast;
        ctl_a.ring = row_reg == 16'd2 || row_reg == hlast ||
                     col_reg == d8sd_pkg::COL_BITS'(2) || col_wide == wlast;
        ctl_a.last = row_reg == hlast && col_wide == wlast;
        ctl_a.col  = col_reg - 1'b1;
        ctl_a.row  = row_reg - 1'b1;
        if (col_wide >= wlast)
        begin
            col_next = '0;
            row_next = (row_reg >= hlast) ? '0 : row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1: line store data arrives
    logic                          s1_valid_reg;
    d8sd_pkg::ctl_t                s1_ctl_reg;
    logic [EB-1:0]                 s1_sample_reg;
    logic [d8sd_pkg::COL_BITS-1:0] s1_addr_reg;
    logic [2*EB-1:0]               line_rdata;
    logic [EB-1:0]                 up;
    logic [EB-1:0]                 mid;
    logic                          line_we;

    assign up      = line_rdata[2*EB-1:EB];
    assign mid     = line_rdata[EB-1:0];
    assign line_we = en && s1_valid_reg;

    d8sd_ram #(
        .WIDTH (2 * EB),
        .DEPTH (d8sd_pkg::MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (line_we),
        .waddr (s1_addr_reg),
        .wdata ({mid, s1_sample_reg}),
        .re    (en),
        .raddr (col_reg),
        .rdata (line_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= samples.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_ctl_reg    <= ctl_a;
            s1_sample_reg <= samples.elevation[EB-1:0];
            s1_addr_reg   <= col_reg;
        end
    end

    // window, w0..w2 older column, w3..w5 newer column, top to bottom
    logic [EB-1:0] win_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 6; k++)
                win_reg[k] <= '0;
        end
        else if (line_we)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= up;
            win_reg[4] <= mid;
            win_reg[5] <= s1_sample_reg;
        end
    end

    // neighbours in direction order: w, nw, n, ne, e, se, s, sw
    logic [EB-1:0] nb [d8sd_pkg::NB_COUNT];
    logic [EB-1:0] drop [d8sd_pkg::NB_COUNT];

    always_comb
    begin
        nb[0] = win_reg[1];
        nb[1] = win_reg[0];
        nb[2] = win_reg[3];
        nb[3] = up;
        nb[4] = mid;
        nb[5] = s1_sample_reg;
        nb[6] = win_reg[5];
        nb[7] = win_reg[2];
        for (int k = 0; k < d8sd_pkg::NB_COUNT; k++)
            drop[k] = (nb[k] < win_reg[4]) ? win_reg[4] - nb[k] : '0;
    end

    // stage 2: positive drops
    logic           s2_valid_reg;
    d8sd_pkg::ctl_t s2_ctl_reg;
    logic [EB-1:0]  s2_drop_reg [d8sd_pkg::NB_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg && s1_ctl_reg.emit;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_ctl_reg <= s1_ctl_reg;
            for (int k = 0; k < d8sd_pkg::NB_COUNT; k++)
                s2_drop_reg[k] <= drop[k];
        end
    end

    // stage 3: weighted drops
    logic           s3_valid_reg;
    d8sd_pkg::ctl_t s3_ctl_reg;
    logic [SB-1:0]  s3_score_reg [d8sd_pkg::NB_COUNT];
    logic [SB-1:0]  score [d8sd_pkg::NB_COUNT];

    always_comb
    begin
        for (int k = 0; k < d8sd_pkg::NB_COUNT; k++)
        begin
            if (k % 2 == 1)
                score[k] = {{d8sd_pkg::WEIGHT_FRAC{1'b0}}, s2_drop_reg[k]} *
                           SB'(d8sd_pkg::DIAG_WEIGHT);
            else
                score[k] = {s2_drop_reg[k], {d8sd_pkg::WEIGHT_FRAC{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_ctl_reg <= s2_ctl_reg;
            for (int k = 0; k < d8sd_pkg::NB_COUNT; k++)
                s3_score_reg[k] <= score[k];
        end
    end

    // stage 4: first compare level, the right side wins only when strictly larger
    logic                  s4_valid_reg;
    d8sd_pkg::ctl_t        s4_ctl_reg;
    d8sd_pkg::cand_t       s4_cand_reg [4];
    d8sd_pkg::cand_t       lvl1 [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (s3_score_reg[2*k+1] > s3_score_reg[2*k])
            begin
                lvl1[k].idx   = d8sd_pkg::NB_BITS'(2 * k + 1);
                lvl1[k].score = s3_score_reg[2*k+1];
            end
            else
            begin
                lvl1[k].idx   = d8sd_pkg::NB_BITS'(2 * k);
                lvl1[k].score = s3_score_reg[2*k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (en)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_ctl_reg <= s3_ctl_reg;
            for (int k = 0; k < 4; k++)
                s4_cand_reg[k] <= lvl1[k];
        end
    end

    // output stage: last two compare levels and no flow decision
    d8sd_pkg::cand_t               lvl2 [2];
    d8sd_pkg::cand_t               best;
    logic [d8sd_pkg::DIR_BITS-1:0] dir_next;

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            if (s4_cand_reg[2*k+1].score > s4_cand_reg[2*k].score)
                lvl2[k] = s4_cand_reg[2*k+1];
            else
                lvl2[k] = s4_cand_reg[2*k];
        end
        best = (lvl2[1].score > lvl2[0].score) ? lvl2[1] : lvl2[0];
        if (s4_ctl_reg.ring || best.score == '0)
            dir_next = d8sd_pkg::NO_FLOW;
        else
            dir_next = {1'b0, best.idx};
    end

    logic [d8sd_pkg::DIR_BITS-1:0] out_dir_reg;
    logic [d8sd_pkg::COL_BITS-1:0] out_col_reg;
    logic [d8sd_pkg::ROW_BITS-1:0] out_row_reg;
    logic                          out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_dir_reg  <= dir_next;
            out_col_reg  <= s4_ctl_reg.col;
            out_row_reg  <= s4_ctl_reg.row;
            out_last_reg <= s4_ctl_reg.last;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.direction   = out_dir_reg;
    assign results.cell_column = out_col_reg;
    assign results.cell_row    = out_row_reg;
    assign results.frame_last  = out_last_reg;

    // checks
    a_accept_enters_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted item missing from stage 1");

    a_last_at_frame_corner: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.frame_last |->
            {1'b0, results.cell_column} == width_reg - 13'd2 &&
            {1'b0, results.cell_row} == {1'b0, height_reg} - 17'd2)
        else $error("frame_last away from last inner cell");

    a_ring_no_flow: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.cell_row == 16'd1 ||
                          results.cell_column == d8sd_pkg::COL_BITS'(1)) |->
            results.direction == d8sd_pkg::NO_FLOW)
        else $error("second ring cell has a flow direction");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> s4_valid_reg == $past(s4_valid_reg) && s1_valid_reg == $past(s1_valid_reg))
        else $error("pipeline moved during stall");

    a_direction_range: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.direction <= d8sd_pkg::NO_FLOW)
        else $error("direction code out of range");

endmodule

FILE: tb/d8_steepest_descent_direction_top_test.sv
// ----------------------------------------------------------------------------
// d8_steepest_descent_direction_top_test
// self-checking bench for the streamed d8 flow direction block
// ----------------------------------------------------------------------------
// Streams raster frames of elevation samples into the block and predicts the
// flow direction of every inner cell with a cycle-free model of the line
// stores and the 3x3 window. Each result item is compared field by field with
// the oldest prediction. Frames are mostly small; one frame runs with long
// rows and one at the full frame height, the latter cut short by a
// register write in the middle of the frame. Both handshake sides stall at
// random, with some phases free of stalls.
// ----------------------------------------------------------------------------
import d8sd_pkg::*;

typedef enum int {DIR_W, DIR_NW, DIR_N, DIR_NE, DIR_E, DIR_SE, DIR_S, DIR_SW} neighbour_e;

typedef struct packed {
    logic [DIR_BITS-1:0] direction;
    logic [COL_BITS-1:0] column;
    logic [ROW_BITS-1:0] row;
    logic                last;
} flow_result_t;

localparam longint unsigned ORTH_WEIGHT = 64'd1 << WEIGHT_FRAC;
localparam int              MAX_REPORTS = 100;

class flow_direction_board;
    logic [ELEV_BITS-1:0] upper_row [MAX_WIDTH];
    logic [ELEV_BITS-1:0] middle_row [MAX_WIDTH];
    logic [ELEV_BITS-1:0] win [6];
    int unsigned          col_pos;
    int unsigned          row_pos;
    logic [WCFG_BITS-1:0] width_reg;
    logic [HCFG_BITS-1:0] height_reg;
    flow_result_t         expected_flows [$];
    int                   mismatch_count;

    function new();
        foreach (upper_row[i]) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        foreach (win[i]) win[i] = '0;
        col_pos        = 0;
        row_pos        = 0;
        width_reg      = RESET_SIZE;
        height_reg     = RESET_SIZE;
        mismatch_count = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        if (idx == REG_ROW_WIDTH)
            width_reg = data[WCFG_BITS-1:0];
        else if (idx == REG_FRAME_HEIGHT)
            height_reg = data[HCFG_BITS-1:0];
    endfunction

    function int unsigned used_width();
        int unsigned w;
        w = width_reg;
        if (w < MIN_SIZE) w = MIN_SIZE;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function int unsigned used_height();
        int unsigned h;
        h = height_reg;
        if (h < MIN_SIZE) h = MIN_SIZE;
        return h;
    endfunction

    function void note_sample(logic [ELEV_FIELD_BITS-1:0] elevation);
        int unsigned          w, h, c, r, cr, cc;
        logic [ELEV_BITS-1:0] sample, up, mid;
        logic [ELEV_BITS-1:0] nb [NB_COUNT];
        longint unsigned      drop, weight, score, best;
        flow_result_t         res;
        sample = elevation[ELEV_BITS-1:0];
        w      = used_width();
        h      = used_height();
        c      = col_pos;
        r      = row_pos;
        up     = upper_row[c];
        mid    = middle_row[c];
        if (r >= 2 && r <= h - 1 && c >= 2 && c <= w - 1) begin
            cr            = r - 1;
            cc            = c - 1;
            res.direction = NO_FLOW;
            res.column    = cc[COL_BITS-1:0];
            res.row       = cr[ROW_BITS-1:0];
            res.last      = (cr == h - 2 && cc == w - 2);
            if (!(cr == 1 || cr == h - 2 || cc == 1 || cc == w - 2)) begin
                nb[DIR_W]  = win[1];
                nb[DIR_NW] = win[0];
                nb[DIR_N]  = win[3];
                nb[DIR_NE] = up;
                nb[DIR_E]  = mid;
                nb[DIR_SE] = sample;
                nb[DIR_S]  = win[5];
                nb[DIR_SW] = win[2];
                best = 0;
                for (int n = 0; n < NB_COUNT; n++) begin
                    if (nb[n] < win[4]) begin
                        drop   = win[4] - nb[n];
                        weight = n[0] ? longint'(DIAG_WEIGHT) : ORTH_WEIGHT;
                        score  = drop * weight;
                        if (score > best) begin
                            best          = score;
                            res.direction = n[DIR_BITS-1:0];
                        end
                    end
                end
            end
            expected_flows.push_back(res);
        end
        win[0]        = win[3];
        win[1]        = win[4];
        win[2]        = win[5];
        win[3]        = up;
        win[4]        = mid;
        win[5]        = sample;
        upper_row[c]  = mid;
        middle_row[c] = sample;
        if (c >= w - 1) begin
            col_pos = 0;
            row_pos = (r >= h - 1) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    task report(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endtask

    task check_result(flow_result_t got);
        flow_result_t want;
        if (expected_flows.size() == 0) begin
            report($sformatf("result item at %0d,%0d with nothing predicted", got.row,
                             got.column));
        end else begin
            want = expected_flows.pop_front();
            if (got.direction !== want.direction)
                report($sformatf("cell %0d,%0d direction %0d, predicted %0d", want.row,
                                 want.column, got.direction, want.direction));
            if (got.column !== want.column)
                report($sformatf("cell %0d,%0d column %0d", want.row, want.column,
                                 got.column));
            if (got.row !== want.row)
                report($sformatf("cell %0d,%0d row %0d", want.row, want.column, got.row));
            if (got.last !== want.last)
                report($sformatf("cell %0d,%0d frame_last %0b, predicted %0b", want.row,
                                 want.column, got.last, want.last));
        end
    endtask
endclass

module d8_steepest_descent_direction_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {ELEV_NOISE, ELEV_TERRACE, ELEV_EXTREME, ELEV_SLOPE} elev_mode_e;

    localparam int SETTLE_CYCLES  = 12;
    localparam int RANDOM_ITEMS   = 1650;
    localparam int LONG_ROW_WIDTH = 100;

    logic                      clk;
    logic                      rst_n;
    logic                      write_enable;
    logic [CFG_INDEX_BITS-1:0] write_index;
    logic [CFG_DATA_BITS-1:0]  write_data;

    d8sd_in_if  samples_if ();
    d8sd_out_if results_if ();

    d8_steepest_descent_direction_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .samples      (samples_if),
        .results      (results_if)
    );

    flow_direction_board  board;
    flow_result_t         seen_flow;
    bit                   quiet;
    elev_mode_e           elev_mode;
    logic [ELEV_BITS-1:0] elev_base;
    int                   slope_row;
    int                   slope_col;
    int                   random_sent;
    logic [ELEV_BITS-1:0] directed_cells [25];

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(negedge clk)
    begin
        results_if.ready <= quiet || ($urandom_range(0, 99) >= 8);
    end

    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready) begin
            seen_flow.direction = results_if.direction;
            seen_flow.column    = results_if.cell_column;
            seen_flow.row       = results_if.cell_row;
            seen_flow.last      = results_if.frame_last;
            board.check_result(seen_flow);
        end
    end

    task automatic send_sample(input logic [ELEV_FIELD_BITS-1:0] e);
        while (!quiet && $urandom_range(0, 99) < 8) begin
            samples_if.valid <= 1'b0;
            @(negedge clk);
        end
        samples_if.valid     <= 1'b1;
        samples_if.elevation <= e;
        @(posedge clk);
        while (!samples_if.ready) @(posedge clk);
        board.note_sample(e);
        @(negedge clk);
    endtask

    task automatic hold_until_empty();
        samples_if.valid <= 1'b0;
        @(negedge clk);
        while (board.expected_flows.size() != 0) @(negedge clk);
    endtask

    task automatic drain();
        hold_until_empty();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        write_enable <= 1'b1;
        write_index  <= idx;
        write_data   <= data;
        @(negedge clk);
        board.set_register(idx, data);
        write_enable <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [ELEV_BITS-1:0] make_elevation();
        case (elev_mode)
            ELEV_NOISE:   return $urandom;
            ELEV_TERRACE: return elev_base + $urandom_range(0, 3);
            ELEV_EXTREME:
                case ($urandom_range(0, 2))
                    0:       return '0;
                    1:       return '1;
                    default: return $urandom;
                endcase
            default:
                return elev_base + board.row_pos * slope_row + board.col_pos * slope_col
                       + $urandom_range(0, 40);
        endcase
    endfunction

    task automatic send_random();
        logic [ELEV_BITS-1:0] e;
        e = make_elevation();
        if ($urandom_range(0, 149) == 0)
            hold_until_empty();
        send_sample(e);
        random_sent++;
    endtask

    task automatic stream_to_frame_end();
        do
            send_random();
        while (!(board.col_pos == 0 && board.row_pos == 0));
    endtask

    // shrink or keep the row width and move the frame end while inside a frame whose rows are stored
    task automatic stream_with_resize(input int unsigned min_row);
        int unsigned stop_col;
        int unsigned new_width;
        stop_col = $urandom_range(0, board.used_width() - 1);
        do
            send_random();
        while (!(board.row_pos >= min_row && board.col_pos == stop_col));
        drain();
        new_width = $urandom_range(0, board.used_width());
        write_register(REG_ROW_WIDTH, new_width[CFG_DATA_BITS-1:0]);
        write_register(REG_FRAME_HEIGHT, CFG_DATA_BITS'($urandom_range(0, 12)));
        while (!(board.col_pos == 0 && board.row_pos == 0))
            send_random();
    endtask

    task automatic pick_terrain();
        elev_mode = elev_mode_e'($urandom_range(0, 3));
        elev_base = $urandom;
        slope_row = $urandom_range(0, 128) - 64;
        slope_col = $urandom_range(0, 128) - 64;
    endtask

    initial
    begin
        #5ms;
        $display("timeout while waiting for the block");
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int unsigned w_cfg;
        int unsigned h_cfg;
        int          frames;
        board                = new();
        quiet                = 1'b0;
        rst_n                = 1'b0;
        write_enable         = 1'b0;
        write_index          = REG_ROW_WIDTH;
        write_data           = '0;
        samples_if.valid     = 1'b0;
        samples_if.elevation = '0;
        results_if.ready     = 1'b0;
        random_sent          = 0;
        elev_mode            = ELEV_NOISE;
        elev_base            = '0;
        slope_row            = 0;
        slope_col            = 0;
        foreach (directed_cells[i]) directed_cells[i] = '0;
        // peak centre: diagonal pit against a near-equal orthogonal drop
        directed_cells[12] = '1;
        directed_cells[18] = '0;
        directed_cells[11] = 32'd1257966796;
        directed_cells[6]  = '1;
        directed_cells[7]  = '1;
        directed_cells[8]  = '1;
        directed_cells[13] = '1;
        directed_cells[16] = '1;
        directed_cells[17] = '1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_register(REG_ROW_WIDTH, CFG_DATA_BITS'(5));
        write_register(REG_FRAME_HEIGHT, CFG_DATA_BITS'(5));
        for (int i = 0; i < 25; i++) begin
            if (i == 13)
                hold_until_empty();
            send_sample(directed_cells[i]);
        end

        // long rows with no random handshake stalls
        drain();
        write_register(REG_ROW_WIDTH, CFG_DATA_BITS'(LONG_ROW_WIDTH));
        write_register(REG_FRAME_HEIGHT, CFG_DATA_BITS'(5));
        quiet     = 1'b1;
        elev_mode = ELEV_NOISE;
        stream_to_frame_end();
        quiet = 1'b0;

        // full frame height, ended early
        drain();
        write_register(REG_ROW_WIDTH, CFG_DATA_BITS'(6));
        write_register(REG_FRAME_HEIGHT, '1);
        pick_terrain();
        stream_with_resize(8);

        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       w_cfg = $urandom_range(0, 4);
                1:       w_cfg = $urandom_range(13, 40);
                default: w_cfg = $urandom_range(5, 12);
            endcase
            h_cfg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 10);
            drain();
            write_register(REG_ROW_WIDTH, w_cfg[CFG_DATA_BITS-1:0]);
            write_register(REG_FRAME_HEIGHT, h_cfg[CFG_DATA_BITS-1:0]);
            quiet  = ($urandom_range(0, 7) == 0);
            frames = $urandom_range(1, 2);
            repeat (frames) begin
                pick_terrain();
                if ($urandom_range(0, 5) == 0)
                    stream_with_resize(2);
                else
                    stream_to_frame_end();
            end
        end
        quiet = 1'b0;
        drain();

        if (board.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

FILE: d8_steepest_descent_direction_top.f
rtl/core/d8sd_pkg.sv
rtl/core/d8sd_if.sv
rtl/core/d8sd_ram.sv
rtl/core/d8_steepest_descent_direction_top.sv
tb/d8_steepest_descent_direction_top_test.sv
